/* sv/tdm_pkg.sv */
// Package for the tile dictionary match block.
// Holds widths, request codes, the scan token type and the controller states.
// No dependencies.
package tdm_pkg;

    // Defaults for the top-level parameters
    localparam int DICT_ENTRIES_DEF = 256;
    localparam int INDEX_BASE_DEF   = 128;

    // Payload widths
    localparam int SLOT_W     = 8;
    localparam int HALF_W     = 64;
    localparam int TILE_W     = 2 * HALF_W;
    localparam int TILE_IDX_W = 8;

    // The tile word is split across a row of compare cells
    localparam int N_CELLS = 4;
    localparam int CELL_W  = TILE_W / N_CELLS;

    // Request codes
    localparam logic REQ_STORE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // Token that walks down the cell row with one entry address
    typedef struct packed {
        logic vld;   // token carries an entry
        logic last;  // final entry of the scan
        logic hit;   // entry valid and all slices so far equal
    } t_tok;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

endpackage

/* sv/tdm_if.sv */
// Handshake channels of the tile dictionary match block.
// tdm_req_if carries request beats, tdm_res_if carries result beats.
// Depends on tdm_pkg for payload widths.
interface tdm_req_if;
    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic [tdm_pkg::SLOT_W-1:0] slot;
    logic [tdm_pkg::HALF_W-1:0] tile_lo;
    logic [tdm_pkg::HALF_W-1:0] tile_hi;

    modport source (output valid, req_type, slot, tile_lo, tile_hi, input ready);
    modport sink   (input valid, req_type, slot, tile_lo, tile_hi, output ready);
endinterface

interface tdm_res_if;
    logic                           valid;
    logic                           ready;
    logic                           found;
    logic [tdm_pkg::TILE_IDX_W-1:0] tile_index;

    modport source (output valid, found, tile_index, input ready);
    modport sink   (input valid, found, tile_index, output ready);
endinterface

/* sv/tdm_cell.sv */
// One compare cell of the dictionary row: stores one slice of every entry.
// Reads its slice at the token's address, compares with the key slice and
// hands token and address to the next cell. Depends on tdm_pkg.
module tdm_cell #(
    parameter int DEPTH = tdm_pkg::DICT_ENTRIES_DEF,
    parameter int AW    = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [tdm_pkg::CELL_W-1:0] i_wr_data,
    input  logic [tdm_pkg::CELL_W-1:0] i_key,
    input  tdm_pkg::t_tok              i_tok,
    input  logic [AW-1:0]              i_addr,
    output tdm_pkg::t_tok              o_tok,
    output logic [AW-1:0]              o_addr
);

    logic [tdm_pkg::CELL_W-1:0] r_mem [DEPTH];
    logic [tdm_pkg::CELL_W-1:0] r_rd_data;
    tdm_pkg::t_tok              r_tok_a;
    logic [AW-1:0]              r_addr_a;
    tdm_pkg::t_tok              r_tok_b;
    logic [AW-1:0]              r_addr_b;
    tdm_pkg::t_tok              n_tok_b;

    // Store one slice, read one slice
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_addr];
    end

    // Hold the token beside the read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_a <= '0;
        end else begin
            r_tok_a <= i_tok;
        end
        r_addr_a <= i_addr;
    end

    // Drop the hit when this slice differs
    always_comb begin
        n_tok_b      = r_tok_a;
        n_tok_b.hit  = r_tok_a.hit && (r_rd_data == i_key);
    end

    // Advance the token to the neighbor
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_b <= '0;
        end else begin
            r_tok_b <= n_tok_b;
        end
        r_addr_b <= r_addr_a;
    end

    assign o_tok  = r_tok_b;
    assign o_addr = r_addr_b;

endmodule

/* sv/tile_dictionary_match.sv */
// Tile dictionary match: a store beat gives no result.
// A lookup scans all DICT_ENTRIES entries in slot order through N_CELLS compare
// cells, one entry per cycle; no new beat is taken until its result has been
// loaded into the result register.
// Synchronous active-low reset clears all valid bits and the controller.
// Depends on tdm_pkg, tdm_if and tdm_cell.
module tile_dictionary_match #(
    parameter int DICT_ENTRIES = tdm_pkg::DICT_ENTRIES_DEF,
    parameter int INDEX_BASE   = tdm_pkg::INDEX_BASE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tdm_req_if.sink     i_req,
    tdm_res_if.source   o_res
);

    localparam int AW = (DICT_ENTRIES > 1) ? $clog2(DICT_ENTRIES) : 1;
    localparam int NC = tdm_pkg::N_CELLS;
    localparam int CW = tdm_pkg::CELL_W;

    tdm_pkg::t_state r_state, n_state;

    logic [DICT_ENTRIES-1:0]            r_entry_valid;
    logic [AW-1:0]                      r_addr;
    logic [tdm_pkg::TILE_W-1:0]         r_key;
    logic                               r_found;
    logic [tdm_pkg::TILE_IDX_W-1:0]     r_idx;
    logic                               r_out_vld;
    logic                               r_out_found;
    logic [tdm_pkg::TILE_IDX_W-1:0]     r_out_idx;

    logic                               in_ready;
    logic                               in_fire;
    logic                               store_ok;
    logic                               scan_last;
    logic                               out_load;
    logic [AW-1:0]                      wr_addr;
    logic [tdm_pkg::TILE_W-1:0]         wr_tile;

    tdm_pkg::t_tok                      tok  [NC+1];
    logic [AW-1:0]                      addr [NC+1];

    assign in_fire   = i_req.valid && in_ready;
    assign store_ok  = in_fire && (i_req.req_type == tdm_pkg::REQ_STORE) &&
                       ({1'b0, i_req.slot} < (tdm_pkg::SLOT_W+1)'(DICT_ENTRIES));
    assign wr_addr   = i_req.slot[AW-1:0];
    assign wr_tile   = {i_req.tile_hi, i_req.tile_lo};
    assign scan_last = (r_addr == AW'(DICT_ENTRIES - 1));

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            tdm_pkg::ST_IDLE: begin
                if (in_fire && (i_req.req_type == tdm_pkg::REQ_LOOKUP)) begin
                    n_state = tdm_pkg::ST_SCAN;
                end
            end
            tdm_pkg::ST_SCAN: begin
                if (scan_last) begin
                    n_state = tdm_pkg::ST_DRAIN;
                end
            end
            tdm_pkg::ST_DRAIN: begin
                if (tok[NC].vld && tok[NC].last) begin
                    n_state = tdm_pkg::ST_DONE;
                end
            end
            tdm_pkg::ST_DONE: begin
                if (!r_out_vld || o_res.ready) begin
                    n_state = tdm_pkg::ST_IDLE;
                end
            end
            default: n_state = tdm_pkg::ST_IDLE;
        endcase
    end

    // Controller outputs: feed the cell row, load the result
    always_comb begin
        in_ready = 1'b0;
        out_load = 1'b0;
        tok[0]   = '0;
        addr[0]  = r_addr;
        case (r_state)
            tdm_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            tdm_pkg::ST_SCAN: begin
                tok[0].vld  = 1'b1;
                tok[0].last = scan_last;
                tok[0].hit  = r_entry_valid[r_addr];
            end
            tdm_pkg::ST_DRAIN: begin
            end
            tdm_pkg::ST_DONE: begin
                out_load = !r_out_vld || o_res.ready;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tdm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Mark stored entries valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_valid <= '0;
        end else if (store_ok) begin
            r_entry_valid[wr_addr] <= 1'b1;
        end
    end

    // Capture the key, step the scan address
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_key <= wr_tile;
        end
        if (in_fire) begin
            r_addr <= '0;
        end else if (r_state == tdm_pkg::ST_SCAN) begin
            r_addr <= r_addr + AW'(1);
        end
    end

    // Keep the first hit leaving the row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (in_fire) begin
            r_found <= 1'b0;
        end else if (tok[NC].vld && tok[NC].hit && !r_found) begin
            r_found <= 1'b1;
        end
        if (in_fire) begin
            r_idx <= '0;
        end else if (tok[NC].vld && tok[NC].hit && !r_found) begin
            r_idx <= tdm_pkg::TILE_IDX_W'(INDEX_BASE) + tdm_pkg::TILE_IDX_W'(addr[NC]);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
        if (out_load) begin
            r_out_found <= r_found;
            r_out_idx   <= r_idx;
        end
    end

    // Row of compare cells, one tile slice each
    for (genvar g = 0; g < NC; g++) begin : g_cell
        tdm_cell #(
            .DEPTH (DICT_ENTRIES),
            .AW    (AW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_wr_en   (store_ok),
            .i_wr_addr (wr_addr),
            .i_wr_data (wr_tile[g*CW +: CW]),
            .i_key     (r_key[g*CW +: CW]),
            .i_tok     (tok[g]),
            .i_addr    (addr[g]),
            .o_tok     (tok[g+1]),
            .o_addr    (addr[g+1])
        );
    end

    assign i_req.ready      = in_ready;
    assign o_res.valid      = r_out_vld;
    assign o_res.found      = r_out_found;
    assign o_res.tile_index = r_out_idx;

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for tile_dictionary_match: store and lookup beats
// against a behavioral dictionary, with random gaps and stalls on both channels.
// Depends on tdm_pkg, tdm_if and the tile_dictionary_match RTL.
module tb_top;

    localparam int N_SLOTS    = tdm_pkg::DICT_ENTRIES_DEF;
    localparam int BASE_INDEX = tdm_pkg::INDEX_BASE_DEF;
    localparam int N_RANDOM   = 1680;
    localparam int DRAIN_CYC  = 600;
    localparam int HOLD_CYC   = 1500;
    localparam int MAX_PRINTS = 100;

    typedef struct packed {
        logic                       req_type;
        logic [tdm_pkg::SLOT_W-1:0] slot;
        logic [tdm_pkg::HALF_W-1:0] tile_lo;
        logic [tdm_pkg::HALF_W-1:0] tile_hi;
    } t_tile_req;

    typedef struct packed {
        logic                           found;
        logic [tdm_pkg::TILE_IDX_W-1:0] tile_index;
    } t_match_res;

    logic i_clk = 1'b0;
    logic i_rst_n;

    tdm_req_if req_ch ();
    tdm_res_if res_ch ();

    tile_dictionary_match #(
        .DICT_ENTRIES(N_SLOTS),
        .INDEX_BASE  (BASE_INDEX)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_res  (res_ch)
    );

    // Behavioral dictionary and expected lookup answers
    logic [tdm_pkg::HALF_W-1:0] dict_lo    [N_SLOTS];
    logic [tdm_pkg::HALF_W-1:0] dict_hi    [N_SLOTS];
    logic                       dict_valid [N_SLOTS];
    t_match_res                 lookup_results_q [$];

    // Stimulus bookkeeping
    t_tile_req                  req_pending_q [$];
    logic [tdm_pkg::TILE_W-1:0] stored_tiles  [$];
    logic [tdm_pkg::TILE_W-1:0] common_tiles  [8];

    int   err_cnt    = 0;
    int   beats_sent = 0;
    int   idle_pct   = 0;
    int   gap_left   = 0;
    int   stall_left = 0;
    logic req_taken  = 1'b0;
    logic hold_res   = 1'b0;

    task automatic report_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS) begin
            $display("[%0t] MISMATCH: %s", $realtime, msg);
        end
    endtask

    // Apply one accepted beat to the dictionary; a lookup yields its answer
    function automatic void apply_request(input t_tile_req it);
        t_match_res r;
        r = '0;
        if (it.req_type == tdm_pkg::REQ_STORE) begin
            if (int'(it.slot) < N_SLOTS) begin
                dict_lo[it.slot]    = it.tile_lo;
                dict_hi[it.slot]    = it.tile_hi;
                dict_valid[it.slot] = 1'b1;
            end
        end else begin
            // first valid slot in ascending order wins
            for (int k = 0; k < N_SLOTS; k++) begin
                if (!r.found && dict_valid[k] &&
                    dict_lo[k] == it.tile_lo && dict_hi[k] == it.tile_hi) begin
                    r.found      = 1'b1;
                    r.tile_index = tdm_pkg::TILE_IDX_W'(BASE_INDEX + k);
                end
            end
            lookup_results_q = {lookup_results_q, r};
        end
    endfunction

    function automatic void queue_req(input logic t, input logic [tdm_pkg::SLOT_W-1:0] s,
                                      input logic [tdm_pkg::TILE_W-1:0] tile);
        t_tile_req it;
        it.req_type = t;
        it.slot     = s;
        it.tile_lo  = tile[tdm_pkg::HALF_W-1:0];
        it.tile_hi  = tile[tdm_pkg::TILE_W-1:tdm_pkg::HALF_W];
        req_pending_q = {req_pending_q, it};
        if (t == tdm_pkg::REQ_STORE) stored_tiles = {stored_tiles, tile};
    endfunction

    function automatic logic [tdm_pkg::TILE_W-1:0] rand_tile();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Mostly no idling, else short gaps with an occasional long one
    function automatic int pick_idle(input int pct);
        if ($urandom_range(0, 99) >= pct) return 0;
        if ($urandom_range(0, 9) == 0) return $urandom_range(20, 80);
        return $urandom_range(1, 3);
    endfunction

    // Clock
    initial begin : clk_gen
        forever #1 i_clk = ~i_clk;
    end

    // Reset and known input values from time zero
    initial begin : reset_seq
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = tdm_pkg::REQ_STORE;
        req_ch.slot      = '0;
        req_ch.tile_lo   = '0;
        req_ch.tile_hi   = '0;
        res_ch.ready     = 1'b0;
        foreach (dict_valid[k]) dict_valid[k] = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Build the beat list: directed cases, then random traffic
    initial begin : stimulus
        logic [tdm_pkg::TILE_W-1:0] ones, pat_a, pat_b, pat_c, tile;
        logic [tdm_pkg::SLOT_W-1:0] slot;
        int                         pick;
        int                         depth;
        ones  = '1;
        pat_a = {64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF};
        pat_b = {64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA};
        pat_c = {64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555};

        // empty dictionary never matches
        queue_req(tdm_pkg::REQ_LOOKUP, 8'h00, '0);
        queue_req(tdm_pkg::REQ_LOOKUP, 8'hFF, ones);
        // lowest slot maps to the index base
        queue_req(tdm_pkg::REQ_STORE,  8'h00, '0);
        queue_req(tdm_pkg::REQ_LOOKUP, 8'h00, '0);
        // highest slot wraps the index around
        queue_req(tdm_pkg::REQ_STORE,  8'hFF, ones);
        queue_req(tdm_pkg::REQ_LOOKUP, 8'h00, ones);
        queue_req(tdm_pkg::REQ_STORE,  8'h7F, pat_a);
        queue_req(tdm_pkg::REQ_LOOKUP, 8'hFF, pat_a);
        // duplicate tiles: lower slot wins
        queue_req(tdm_pkg::REQ_STORE,  8'd40, pat_b);
        queue_req(tdm_pkg::REQ_STORE,  8'd20, pat_b);
        queue_req(tdm_pkg::REQ_LOOKUP, 8'h55, pat_b);
        // rewrite a slot: old tile now only in the higher slot
        queue_req(tdm_pkg::REQ_STORE,  8'd20, pat_c);
        queue_req(tdm_pkg::REQ_LOOKUP, 8'hAA, pat_b);
        queue_req(tdm_pkg::REQ_LOOKUP, 8'h01, pat_c);
        // one bit off in either half misses
        queue_req(tdm_pkg::REQ_LOOKUP, 8'h00,
                  ones ^ {1'b1, {(tdm_pkg::TILE_W-1){1'b0}}});
        queue_req(tdm_pkg::REQ_LOOKUP, 8'h00, ones ^ tdm_pkg::TILE_W'(1));
        // the same tile in slots 0 and 255
        queue_req(tdm_pkg::REQ_STORE,  8'h00, ones);
        queue_req(tdm_pkg::REQ_LOOKUP, 8'h80, ones);
        queue_req(tdm_pkg::REQ_LOOKUP, 8'h00, '0);

        foreach (common_tiles[k]) common_tiles[k] = rand_tile();

        repeat (N_RANDOM) begin
            if ($urandom_range(0, 99) < 45) begin
                pick = $urandom_range(0, 9);
                if (pick < 6)       tile = rand_tile();
                else if (pick < 9)  tile = common_tiles[$urandom_range(0, 7)];
                else                tile = $urandom_range(0, 1) ? ones : '0;
                if ($urandom_range(0, 9) == 0) slot = $urandom_range(0, 1) ? 8'hFF : 8'h00;
                else                           slot = tdm_pkg::SLOT_W'($urandom_range(0, 255));
                queue_req(tdm_pkg::REQ_STORE, slot, tile);
            end else begin
                pick  = $urandom_range(0, 99);
                depth = (stored_tiles.size() < 64) ? stored_tiles.size() : 64;
                if (depth > 0 && pick < 70) begin
                    // favor recent stores, which are most likely still present
                    tile = stored_tiles[stored_tiles.size() - 1 - $urandom_range(0, depth - 1)];
                    if (pick >= 55) begin
                        tile = tile ^ (tdm_pkg::TILE_W'(1) <<
                                       $urandom_range(0, tdm_pkg::TILE_W - 1));
                    end
                end else if (pick < 85) begin
                    tile = common_tiles[$urandom_range(0, 7)];
                end else begin
                    tile = rand_tile();
                end
                queue_req(tdm_pkg::REQ_LOOKUP, tdm_pkg::SLOT_W'($urandom_range(0, 255)), tile);
            end
        end
    end

    // Switch between calm stretches and stretches with idling
    initial begin : idle_phase
        forever begin
            repeat (400) @(posedge i_clk);
            idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 30;
        end
    end

    // Request driver: hold a beat until taken, then advance
    always @(negedge i_clk) begin : req_drive
        t_tile_req it;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_taken) begin
            req_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else if (req_pending_q.size() > 0) begin
                it = req_pending_q.pop_front();
                req_ch.req_type <= it.req_type;
                req_ch.slot     <= it.slot;
                req_ch.tile_lo  <= it.tile_lo;
                req_ch.tile_hi  <= it.tile_hi;
                req_ch.valid    <= 1'b1;
                gap_left = pick_idle(idle_pct);
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Result ready: random stalls, plus the long hold-off
    always @(negedge i_clk) begin : res_ready_drive
        if (!i_rst_n || hold_res) begin
            res_ch.ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            res_ch.ready <= 1'b0;
        end else begin
            res_ch.ready <= 1'b1;
            stall_left = pick_idle(idle_pct);
        end
    end

    // Hold off the result side long enough for the block to back up
    initial begin : res_hold_off
        wait (beats_sent >= 400);
        @(posedge i_clk);
        hold_res = 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_res = 1'b0;
    end

    // Sample beats on both channels: predict requests, check results
    always @(posedge i_clk) begin : beat_observe
        t_tile_req  it;
        t_match_res want;
        if (i_rst_n) begin
            if (req_ch.valid && req_ch.ready) begin
                it = {req_ch.req_type, req_ch.slot, req_ch.tile_lo, req_ch.tile_hi};
                apply_request(it);
                req_taken = 1'b1;
                beats_sent++;
            end
            if (res_ch.valid && res_ch.ready) begin
                if (lookup_results_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result found=%0b tile_index=%0d",
                                              res_ch.found, res_ch.tile_index));
                end else begin
                    want = lookup_results_q.pop_front();
                    if (res_ch.found !== want.found)
                        report_mismatch($sformatf("found=%0b, want %0b",
                                                  res_ch.found, want.found));
                    if (res_ch.tile_index !== want.tile_index)
                        report_mismatch($sformatf("tile_index=%0d, want %0d",
                                                  res_ch.tile_index, want.tile_index));
                end
            end
        end
    end

    // Wait for all beats to go through, drain, then report
    initial begin : finish_run
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        while (req_pending_q.size() != 0 || req_ch.valid || lookup_results_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
        if (lookup_results_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", lookup_results_q.size()));
        end
        if (err_cnt == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin : watchdog
        #6_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
